// ===== hdl/cwlc_pkg.sv =====
`default_nettype none
package cwlc_pkg;

  localparam int MAX_CLUSTERS = 16;
  localparam int FEATURE_DIM = 4;
  localparam int CONTEXT_DIM = 2;
  localparam int NUM_LANES = FEATURE_DIM + CONTEXT_DIM;

  localparam int IDX_W = $clog2(MAX_CLUSTERS);
  localparam int TOT_W = IDX_W + 1;
  localparam int VAL_W = 16;
  localparam int SUM_W = 32;
  localparam int CNT_W = 16;
  localparam int STEP_W = $clog2(SUM_W);
  localparam int MEAN_W = VAL_W + 1;
  localparam int DIFF_W = MEAN_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int ROOT_W = (PROD_W + $clog2(FEATURE_DIM) + 1) / 2;
  localparam int SQ_W = 2 * ROOT_W;
  localparam int DOT_W = PROD_W + $clog2(CONTEXT_DIM);
  localparam int W_W = 9;
  localparam int THR_W = 16;
  localparam int SCORE_W = 40;
  localparam int STATUS_W = 3;

  localparam logic [W_W-1:0] W_ONE = W_W'(256);
  localparam logic [W_W-1:0] W_RESET = W_W'(128);
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(256);
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [STATUS_W-1:0] {
    ST_JOINED  = 3'd0,
    ST_CREATED = 3'd1,
    ST_DROPPED = 3'd2,
    ST_PREDICT = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef enum logic {
    REG_WEIGHT    = 1'b0,
    REG_THRESHOLD = 1'b1
  } reg_index_t;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_START, S_DIV, S_PROD, S_SUM, S_SQRT, S_SCORE,
    S_SELECT, S_DECIDE, S_UPD_RD, S_UPD_WR, S_DONE
  } state_t;

  typedef struct packed {
    logic rd;
    logic start;
    logic step;
    logic prod;
    logic wr;
    logic add;
  } lane_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/cwlc_lane.sv =====
`default_nettype none
module cwlc_lane (
  input  wire logic                                clk,
  input  wire cwlc_pkg::lane_ctrl_t                ctrl,
  input  wire logic [cwlc_pkg::IDX_W-1:0]          addr,
  input  wire logic                                square,
  input  wire logic signed [cwlc_pkg::VAL_W-1:0]   x,
  input  wire logic [cwlc_pkg::CNT_W-1:0]          divisor,
  output logic signed [cwlc_pkg::PROD_W-1:0]       prod
);

  logic signed [cwlc_pkg::SUM_W-1:0] sum_mem [cwlc_pkg::MAX_CLUSTERS];
  logic signed [cwlc_pkg::SUM_W-1:0] sum_q;
  logic [cwlc_pkg::SUM_W-1:0] quo;
  logic [cwlc_pkg::CNT_W-1:0] rem;
  logic neg;
  logic [cwlc_pkg::CNT_W:0] rem_sh;
  logic signed [cwlc_pkg::MEAN_W-1:0] mean;
  logic signed [cwlc_pkg::DIFF_W-1:0] diff;
  logic signed [cwlc_pkg::MEAN_W-1:0] x_ext;

  always_ff @(posedge clk) begin
    if (ctrl.rd) begin
      sum_q <= sum_mem[addr];
    end
    if (ctrl.wr) begin
      sum_mem[addr] <= ctrl.add ? sum_q + cwlc_pkg::SUM_W'(x) : cwlc_pkg::SUM_W'(x);
    end
  end

  assign rem_sh = {rem, quo[cwlc_pkg::SUM_W-1]};

  // Restoring division of the sum magnitude, one quotient bit a cycle.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      neg <= sum_q[cwlc_pkg::SUM_W-1];
      quo <= sum_q[cwlc_pkg::SUM_W-1] ? -sum_q : sum_q;
      rem <= '0;
    end else if (ctrl.step) begin
      if (rem_sh >= {1'b0, divisor}) begin
        rem <= cwlc_pkg::CNT_W'(rem_sh - {1'b0, divisor});
        quo <= {quo[cwlc_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[cwlc_pkg::CNT_W-1:0];
        quo <= {quo[cwlc_pkg::SUM_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    mean = neg ? -$signed({1'b0, quo[cwlc_pkg::VAL_W-1:0]})
               : $signed({1'b0, quo[cwlc_pkg::VAL_W-1:0]});
    x_ext = cwlc_pkg::MEAN_W'(x);
    diff = cwlc_pkg::DIFF_W'(x_ext) - cwlc_pkg::DIFF_W'(mean);
  end

  always_ff @(posedge clk) begin
    if (ctrl.prod) begin
      prod <= square ? cwlc_pkg::PROD_W'(diff * diff) : cwlc_pkg::PROD_W'(x_ext * mean);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/cwlc_sqrt.sv =====
`default_nettype none
module cwlc_sqrt (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [cwlc_pkg::SQ_W-1:0]    x,
  output logic                              done,
  output logic [cwlc_pkg::ROOT_W-1:0]       root
);

  logic [cwlc_pkg::SQ_W-1:0] rem;
  logic [cwlc_pkg::SQ_W-1:0] r;
  logic [cwlc_pkg::SQ_W-1:0] bitv;
  logic run;
  logic [cwlc_pkg::SQ_W-1:0] trial;

  assign trial = r + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && bitv[0];
      if (start) begin
        run <= 1'b1;
      end else if (run && bitv[0]) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= x;
      r <= '0;
      bitv <= cwlc_pkg::SQ_W'(1) << (cwlc_pkg::SQ_W - 2);
    end else if (run) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        r <= (r >> 1) + bitv;
      end else begin
        r <= r >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  assign root = r[cwlc_pkg::ROOT_W-1:0];

endmodule
`default_nettype wire

// ===== hdl/context_weighted_leader_clustering_unit.sv =====
`default_nettype none
// Context-weighted leader clustering unit.
// Input items arrive on in_valid/in_stall: opcode (fit or predict), four
// Q8.8 features and two Q8.8 context values. A beat is taken when in_valid
// is high and in_stall is low. Each item gives exactly one result beat on
// out_valid/out_stall carrying status, cluster_index and best_score.
// Configuration is written through wr_en, wr_index and wr_data; the user must
// write it only while the block is idle, as the block does not enforce this.
// One item at a time is processed. For each stored cluster, one lane per
// dimension runs a 32-step serial division for the mean, then a 19-step
// square root unit and the score multipliers follow. A fit that joins a
// cluster reads and then writes the cluster's sums and count, skipping the
// write if the count is saturated; a new cluster is written directly.
// A finished result waits in the output register while the next item is
// taken; if the receiver stalls long enough the block holds in its final
// state until the register frees. Reset empties the cluster table, drops
// any pending result and restores weight 128 and threshold 256.
module context_weighted_leader_clustering_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               opcode,
  input  wire logic signed [cwlc_pkg::VAL_W-1:0]  feature_0,
  input  wire logic signed [cwlc_pkg::VAL_W-1:0]  feature_1,
  input  wire logic signed [cwlc_pkg::VAL_W-1:0]  feature_2,
  input  wire logic signed [cwlc_pkg::VAL_W-1:0]  feature_3,
  input  wire logic signed [cwlc_pkg::VAL_W-1:0]  context_0,
  input  wire logic signed [cwlc_pkg::VAL_W-1:0]  context_1,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [cwlc_pkg::STATUS_W-1:0]           status,
  output logic [cwlc_pkg::IDX_W-1:0]              cluster_index,
  output logic signed [cwlc_pkg::SCORE_W-1:0]     best_score,
  input  wire logic                               wr_en,
  input  wire logic                               wr_index,
  input  wire logic [cwlc_pkg::THR_W-1:0]         wr_data
);

  cwlc_pkg::state_t state, state_next;
  cwlc_pkg::lane_ctrl_t ctrl;

  logic [cwlc_pkg::W_W-1:0] weight;
  logic [cwlc_pkg::THR_W-1:0] threshold;
  logic [cwlc_pkg::TOT_W-1:0] cluster_total;
  logic predict;
  logic signed [cwlc_pkg::VAL_W-1:0] lane_x [cwlc_pkg::NUM_LANES];
  logic signed [cwlc_pkg::PROD_W-1:0] lane_prod [cwlc_pkg::NUM_LANES];
  logic [cwlc_pkg::IDX_W-1:0] addr;
  logic [cwlc_pkg::IDX_W-1:0] cur;
  logic [cwlc_pkg::STEP_W-1:0] step_cnt;
  logic [cwlc_pkg::CNT_W-1:0] count_mem [cwlc_pkg::MAX_CLUSTERS];
  logic [cwlc_pkg::CNT_W-1:0] cnt_q;
  logic [cwlc_pkg::CNT_W-1:0] divisor;
  logic found;
  logic [cwlc_pkg::IDX_W-1:0] best;
  logic signed [cwlc_pkg::SCORE_W-1:0] best_val;
  logic create;
  logic [cwlc_pkg::STATUS_W-1:0] res_status;
  logic [cwlc_pkg::IDX_W-1:0] res_index;
  logic signed [cwlc_pkg::SCORE_W-1:0] res_score;
  logic [cwlc_pkg::SQ_W-1:0] sq_sum;
  logic signed [cwlc_pkg::DOT_W-1:0] dot_sum;
  logic signed [cwlc_pkg::DOT_W-1:0] dot;
  logic sqrt_done;
  logic [cwlc_pkg::ROOT_W-1:0] root;
  logic [cwlc_pkg::W_W-1:0] w_eff;
  logic [cwlc_pkg::W_W-1:0] w_comp;
  logic [cwlc_pkg::SCORE_W-1:0] term_a;
  logic signed [cwlc_pkg::SCORE_W-1:0] term_b;
  logic signed [cwlc_pkg::DOT_W+cwlc_pkg::W_W:0] dot_w;
  logic signed [cwlc_pkg::SCORE_W-1:0] score;
  logic signed [cwlc_pkg::SCORE_W-1:0] limit;
  logic last_cluster;
  logic in_accept;
  logic out_load;

  assign in_accept = in_valid && !in_stall;
  assign w_eff = (weight > cwlc_pkg::W_ONE) ? cwlc_pkg::W_ONE : weight;
  assign w_comp = cwlc_pkg::W_ONE - w_eff;
  assign limit = $signed({(cwlc_pkg::SCORE_W - cwlc_pkg::THR_W - 8)'(0), threshold, 8'd0});
  assign divisor = (cnt_q == '0) ? cwlc_pkg::CNT_W'(1) : cnt_q;
  assign last_cluster = (cwlc_pkg::TOT_W'(cur) + cwlc_pkg::TOT_W'(1)) == cluster_total;
  assign score = $signed(term_a) + term_b;
  assign dot_w = dot * $signed({1'b0, w_eff});

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= cwlc_pkg::W_RESET;
      threshold <= cwlc_pkg::THR_RESET;
    end else if (wr_en) begin
      case (cwlc_pkg::reg_index_t'(wr_index))
        cwlc_pkg::REG_WEIGHT: weight <= wr_data[cwlc_pkg::W_W-1:0];
        cwlc_pkg::REG_THRESHOLD: threshold <= wr_data;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < cwlc_pkg::NUM_LANES; i++) begin : g_lane
    cwlc_lane u_lane (
      .clk(clk),
      .ctrl(ctrl),
      .addr(addr),
      .square(i < cwlc_pkg::FEATURE_DIM),
      .x(lane_x[i]),
      .divisor(divisor),
      .prod(lane_prod[i])
    );
  end

  always_comb begin
    sq_sum = '0;
    dot_sum = '0;
    for (int i = 0; i < cwlc_pkg::FEATURE_DIM; i++) begin
      sq_sum = sq_sum + cwlc_pkg::SQ_W'(unsigned'(lane_prod[i]));
    end
    for (int i = cwlc_pkg::FEATURE_DIM; i < cwlc_pkg::NUM_LANES; i++) begin
      dot_sum = dot_sum + cwlc_pkg::DOT_W'(lane_prod[i]);
    end
  end

  cwlc_sqrt u_sqrt (
    .clk(clk),
    .rst(rst),
    .start(state == cwlc_pkg::S_SUM),
    .x(sq_sum),
    .done(sqrt_done),
    .root(root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cwlc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl = '0;
    in_stall = 1'b1;
    out_load = 1'b0;
    case (state)
      cwlc_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = (cluster_total == '0) ? cwlc_pkg::S_DECIDE : cwlc_pkg::S_READ;
        end
      end
      cwlc_pkg::S_READ: begin
        ctrl.rd = 1'b1;
        state_next = cwlc_pkg::S_START;
      end
      cwlc_pkg::S_START: begin
        ctrl.start = 1'b1;
        state_next = cwlc_pkg::S_DIV;
      end
      cwlc_pkg::S_DIV: begin
        ctrl.step = 1'b1;
        if (step_cnt == cwlc_pkg::STEP_W'(cwlc_pkg::SUM_W - 1)) begin
          state_next = cwlc_pkg::S_PROD;
        end
      end
      cwlc_pkg::S_PROD: begin
        ctrl.prod = 1'b1;
        state_next = cwlc_pkg::S_SUM;
      end
      cwlc_pkg::S_SUM: state_next = cwlc_pkg::S_SQRT;
      cwlc_pkg::S_SQRT: begin
        if (sqrt_done) begin
          state_next = cwlc_pkg::S_SCORE;
        end
      end
      cwlc_pkg::S_SCORE: state_next = cwlc_pkg::S_SELECT;
      cwlc_pkg::S_SELECT: begin
        state_next = last_cluster ? cwlc_pkg::S_DECIDE : cwlc_pkg::S_READ;
      end
      cwlc_pkg::S_DECIDE: begin
        if (predict) begin
          state_next = cwlc_pkg::S_DONE;
        end else if (found) begin
          state_next = cwlc_pkg::S_UPD_RD;
        end else if (cluster_total < cwlc_pkg::TOT_W'(cwlc_pkg::MAX_CLUSTERS)) begin
          state_next = cwlc_pkg::S_UPD_WR;
        end else begin
          state_next = cwlc_pkg::S_DONE;
        end
      end
      cwlc_pkg::S_UPD_RD: begin
        ctrl.rd = 1'b1;
        state_next = cwlc_pkg::S_UPD_WR;
      end
      cwlc_pkg::S_UPD_WR: begin
        ctrl.wr = create || (cnt_q != cwlc_pkg::COUNT_MAX);
        ctrl.add = !create;
        state_next = cwlc_pkg::S_DONE;
      end
      cwlc_pkg::S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load = 1'b1;
          state_next = cwlc_pkg::S_IDLE;
        end
      end
      default: state_next = cwlc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      predict <= opcode;
      lane_x[0] <= feature_0;
      lane_x[1] <= feature_1;
      lane_x[2] <= feature_2;
      lane_x[3] <= feature_3;
      lane_x[4] <= context_0;
      lane_x[5] <= context_1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd) begin
      cnt_q <= count_mem[addr];
    end
    if (state == cwlc_pkg::S_UPD_WR && ctrl.wr) begin
      count_mem[addr] <= create ? cwlc_pkg::CNT_W'(1) : cnt_q + cwlc_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      cwlc_pkg::S_IDLE: begin
        cur <= '0;
        addr <= '0;
        found <= 1'b0;
        best <= '0;
        best_val <= '0;
        create <= 1'b0;
      end
      cwlc_pkg::S_START: step_cnt <= '0;
      cwlc_pkg::S_DIV: step_cnt <= step_cnt + cwlc_pkg::STEP_W'(1);
      cwlc_pkg::S_SUM: dot <= dot_sum;
      cwlc_pkg::S_SCORE: begin
        term_a <= cwlc_pkg::SCORE_W'(root * w_comp);
        term_b <= cwlc_pkg::SCORE_W'(dot_w >>> 8);
      end
      cwlc_pkg::S_SELECT: begin
        if ((predict || score < limit) && (!found || score < best_val)) begin
          found <= 1'b1;
          best <= cur;
          best_val <= score;
        end
        cur <= cur + cwlc_pkg::IDX_W'(1);
        addr <= cur + cwlc_pkg::IDX_W'(1);
      end
      cwlc_pkg::S_DECIDE: begin
        if (predict) begin
          res_status <= found ? cwlc_pkg::ST_PREDICT : cwlc_pkg::ST_EMPTY;
          res_index <= found ? best : '0;
          res_score <= found ? best_val : '0;
        end else if (found) begin
          res_status <= cwlc_pkg::ST_JOINED;
          res_index <= best;
          res_score <= best_val;
          addr <= best;
        end else if (cluster_total < cwlc_pkg::TOT_W'(cwlc_pkg::MAX_CLUSTERS)) begin
          res_status <= cwlc_pkg::ST_CREATED;
          res_index <= cluster_total[cwlc_pkg::IDX_W-1:0];
          res_score <= '0;
          addr <= cluster_total[cwlc_pkg::IDX_W-1:0];
          create <= 1'b1;
        end else begin
          res_status <= cwlc_pkg::ST_DROPPED;
          res_index <= '0;
          res_score <= '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_total <= '0;
    end else if (state == cwlc_pkg::S_UPD_WR && create) begin
      cluster_total <= cluster_total + cwlc_pkg::TOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status <= res_status;
      cluster_index <= res_index;
      best_score <= res_score;
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    cluster_total <= cwlc_pkg::TOT_W'(cwlc_pkg::MAX_CLUSTERS))
    else $error("cluster table overfilled");

  a_create_grows: assert property (@(posedge clk) disable iff (rst)
    (state == cwlc_pkg::S_UPD_WR && create) |=>
      cluster_total == $past(cluster_total) + cwlc_pkg::TOT_W'(1))
    else $error("new cluster did not grow the table");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (out_load && res_status == cwlc_pkg::ST_DROPPED) |->
      cluster_total == cwlc_pkg::TOT_W'(cwlc_pkg::MAX_CLUSTERS))
    else $error("item dropped with room in the table");

  a_created_zero: assert property (@(posedge clk) disable iff (rst)
    (out_load && res_status == cwlc_pkg::ST_CREATED) |-> res_score == '0)
    else $error("created cluster reports a score");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
module tb;

  localparam logic OP_FIT = 1'b0;
  localparam logic OP_PREDICT = 1'b1;
  localparam longint SCORE_MASK = 64'hFF_FFFF_FFFF;

  typedef struct {
    logic op;
    logic signed [cwlc_pkg::VAL_W-1:0] feat [cwlc_pkg::FEATURE_DIM];
    logic signed [cwlc_pkg::VAL_W-1:0] ctx [cwlc_pkg::CONTEXT_DIM];
  } point_t;

  typedef struct {
    cwlc_pkg::status_t status;
    logic [cwlc_pkg::IDX_W-1:0] index;
    logic [cwlc_pkg::SCORE_W-1:0] score;
  } outcome_t;

  typedef struct {
    point_t pt;
    bit typed;
    outcome_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = 1'b0;
  logic signed [cwlc_pkg::VAL_W-1:0] feature_0 = '0, feature_1 = '0;
  logic signed [cwlc_pkg::VAL_W-1:0] feature_2 = '0, feature_3 = '0;
  logic signed [cwlc_pkg::VAL_W-1:0] context_0 = '0, context_1 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [cwlc_pkg::STATUS_W-1:0] status;
  logic [cwlc_pkg::IDX_W-1:0] cluster_index;
  logic signed [cwlc_pkg::SCORE_W-1:0] best_score;
  logic wr_en = 1'b0;
  logic wr_index = 1'b0;
  logic [cwlc_pkg::THR_W-1:0] wr_data = '0;

  context_weighted_leader_clustering_unit dut (.*);

  always #5 clk = ~clk;

  int feat_total [cwlc_pkg::MAX_CLUSTERS][cwlc_pkg::FEATURE_DIM];
  int ctx_total [cwlc_pkg::MAX_CLUSTERS][cwlc_pkg::CONTEXT_DIM];
  int unsigned members [cwlc_pkg::MAX_CLUSTERS];
  int unsigned used_clusters = 0;
  int unsigned weight_reg = 128;
  int unsigned threshold_reg = 256;

  outcome_t pending_q [$];
  int errors = 0;
  bit gaps_on = 1'b1;
  point_t centers [cwlc_pkg::MAX_CLUSTERS];

  function automatic longint root_floor(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint cluster_cost(int k, point_t p, longint w);
    longint cnt, mean, d, sq, dot;
    cnt = (members[k] == 0) ? 1 : longint'(members[k]);
    sq = 0;
    dot = 0;
    for (int i = 0; i < cwlc_pkg::FEATURE_DIM; i++) begin
      mean = longint'(feat_total[k][i]) / cnt;
      d = longint'(p.feat[i]) - mean;
      sq += d * d;
    end
    for (int i = 0; i < cwlc_pkg::CONTEXT_DIM; i++) begin
      mean = longint'(ctx_total[k][i]) / cnt;
      dot += longint'(p.ctx[i]) * mean;
    end
    return root_floor(sq) * (256 - w) + ((dot * w) >>> 8);
  endfunction

  function automatic outcome_t classify_point(point_t p);
    outcome_t o;
    longint w, limit, s, best_s;
    bit found;
    int best;
    w = (weight_reg > 256) ? 256 : longint'(weight_reg);
    limit = longint'(threshold_reg) * 256;
    found = 1'b0;
    best = 0;
    best_s = 0;
    for (int k = 0; k < used_clusters; k++) begin
      s = cluster_cost(k, p, w);
      if (p.op == OP_FIT && s >= limit) continue;
      if (!found || s < best_s) begin
        found = 1'b1;
        best = k;
        best_s = s;
      end
    end
    if (p.op == OP_PREDICT) begin
      o.status = found ? cwlc_pkg::ST_PREDICT : cwlc_pkg::ST_EMPTY;
    end else if (found) begin
      o.status = cwlc_pkg::ST_JOINED;
      if (members[best] < 65535) begin
        members[best]++;
        for (int i = 0; i < cwlc_pkg::FEATURE_DIM; i++)
          feat_total[best][i] += int'(p.feat[i]);
        for (int i = 0; i < cwlc_pkg::CONTEXT_DIM; i++)
          ctx_total[best][i] += int'(p.ctx[i]);
      end
    end else if (used_clusters < cwlc_pkg::MAX_CLUSTERS) begin
      o.status = cwlc_pkg::ST_CREATED;
      best = used_clusters;
      members[best] = 1;
      for (int i = 0; i < cwlc_pkg::FEATURE_DIM; i++) feat_total[best][i] = int'(p.feat[i]);
      for (int i = 0; i < cwlc_pkg::CONTEXT_DIM; i++) ctx_total[best][i] = int'(p.ctx[i]);
      used_clusters++;
    end else begin
      o.status = cwlc_pkg::ST_DROPPED;
      best = 0;
    end
    if (!found) best_s = 0;
    if (o.status == cwlc_pkg::ST_DROPPED || o.status == cwlc_pkg::ST_EMPTY) best = 0;
    o.index = cwlc_pkg::IDX_W'(best);
    o.score = cwlc_pkg::SCORE_W'(best_s & SCORE_MASK);
    return o;
  endfunction

  // Handing off a beat starts once the previous beat was taken, with random idle gaps while gaps_on is set.
  task automatic send_point(point_t p, bit typed, outcome_t want);
    outcome_t o;
    do @(posedge clk); while (gaps_on && $urandom_range(99) < 18);
    in_valid <= 1'b1;
    opcode <= p.op;
    feature_0 <= p.feat[0];
    feature_1 <= p.feat[1];
    feature_2 <= p.feat[2];
    feature_3 <= p.feat[3];
    context_0 <= p.ctx[0];
    context_1 <= p.ctx[1];
    do @(posedge clk); while (in_stall);
    in_valid <= 1'b0;
    o = classify_point(p);
    pending_q.insert(pending_q.size(), typed ? want : o);
  endtask

  task automatic drain;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cwlc_pkg::reg_index_t idx, logic [cwlc_pkg::THR_W-1:0] value);
    drain();
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= value;
    @(posedge clk);
    wr_en <= 1'b0;
    if (idx == cwlc_pkg::REG_WEIGHT) weight_reg = value[cwlc_pkg::W_W-1:0];
    else threshold_reg = value;
  endtask

  function automatic point_t make_point(logic op, int f0, int f1, int f2, int f3,
                                        int c0, int c1);
    point_t p;
    p.op = op;
    p.feat[0] = cwlc_pkg::VAL_W'(f0);
    p.feat[1] = cwlc_pkg::VAL_W'(f1);
    p.feat[2] = cwlc_pkg::VAL_W'(f2);
    p.feat[3] = cwlc_pkg::VAL_W'(f3);
    p.ctx[0] = cwlc_pkg::VAL_W'(c0);
    p.ctx[1] = cwlc_pkg::VAL_W'(c1);
    return p;
  endfunction

  function automatic row_t make_row(point_t p, bit typed, cwlc_pkg::status_t st, int idx);
    row_t r;
    r.pt = p;
    r.typed = typed;
    r.want.status = st;
    r.want.index = cwlc_pkg::IDX_W'(idx);
    r.want.score = '0;
    return r;
  endfunction

  function automatic point_t random_point();
    point_t p;
    int spread, pick;
    p.op = ($urandom_range(99) < 30) ? OP_PREDICT : OP_FIT;
    if ($urandom_range(99) < 70) begin
      pick = $urandom_range(cwlc_pkg::MAX_CLUSTERS - 1);
      case ($urandom_range(2))
        0: spread = 16;
        1: spread = 128;
        default: spread = 1024;
      endcase
      for (int i = 0; i < cwlc_pkg::FEATURE_DIM; i++)
        p.feat[i] = centers[pick].feat[i]
                    + cwlc_pkg::VAL_W'($urandom_range(2 * spread) - spread);
      for (int i = 0; i < cwlc_pkg::CONTEXT_DIM; i++)
        p.ctx[i] = cwlc_pkg::VAL_W'($urandom_range(1024) - 512);
    end else begin
      for (int i = 0; i < cwlc_pkg::FEATURE_DIM; i++) p.feat[i] = cwlc_pkg::VAL_W'($urandom());
      for (int i = 0; i < cwlc_pkg::CONTEXT_DIM; i++) p.ctx[i] = cwlc_pkg::VAL_W'($urandom());
    end
    return p;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= gaps_on && ($urandom_range(99) < 18);
    end
  end

  always @(posedge clk) begin
    outcome_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result beat: status %0d index %0d score %0d",
               status, cluster_index, best_score);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status);
          errors++;
        end
        if (cluster_index !== e.index) begin
          $error("cluster_index expected %0d actual %0d", e.index, cluster_index);
          errors++;
        end
        if (best_score !== e.score) begin
          $error("best_score expected %0d actual %0d", $signed(e.score), best_score);
          errors++;
        end
      end
    end
  end

  initial begin
    #200_000_000;
    $display("FAIL context_weighted_leader_clustering_unit");
    $finish;
  end

  initial begin
    row_t rows [$];
    outcome_t none;
    int weights [7] = '{128, 0, 256, 511, 0, 200, 64};
    int limits [7] = '{256, 0, 65535, 1000, 65535, 4000, 2000};
    none.status = cwlc_pkg::ST_JOINED;
    none.index = '0;
    none.score = '0;
    for (int k = 0; k < cwlc_pkg::MAX_CLUSTERS; k++) centers[k] = make_point(OP_FIT,
      $urandom(), $urandom(), $urandom(), $urandom(), 0, 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // An empty table gives "no clusters" on predict and a new cluster on fit.
    rows = {rows, make_row(make_point(OP_PREDICT, 5, -5, 7, 9, 3, 4),
                           1, cwlc_pkg::ST_EMPTY, 0)};
    rows = {rows, make_row(make_point(OP_FIT, 0, 0, 0, 0, 0, 0),
                           1, cwlc_pkg::ST_CREATED, 0)};
    rows = {rows, make_row(make_point(OP_FIT, 32767, 32767, 32767, 32767, 0, 0),
                           1, cwlc_pkg::ST_CREATED, 1)};
    rows = {rows, make_row(make_point(OP_FIT, -32768, -32768, -32768, -32768, 0, 0),
                           1, cwlc_pkg::ST_CREATED, 2)};
    rows = {rows, make_row(make_point(OP_FIT, 1, 0, -1, 0, 0, 0),
                           0, cwlc_pkg::ST_JOINED, 0)};
    rows = {rows, make_row(make_point(OP_FIT, 0, 0, 0, 0, 32767, -32768),
                           0, cwlc_pkg::ST_JOINED, 0)};
    rows = {rows, make_row(make_point(OP_PREDICT, 0, 0, 0, 0, 0, 0),
                           0, cwlc_pkg::ST_JOINED, 0)};
    rows = {rows, make_row(make_point(OP_PREDICT, 32767, -32768, 32767, -32768,
                                      -32768, 32767), 0, cwlc_pkg::ST_JOINED, 0)};
    rows = {rows, make_row(make_point(OP_PREDICT, 16000, 16000, 16000, 16000, 0, 0),
                           0, cwlc_pkg::ST_JOINED, 0)};
    rows = {rows, make_row(make_point(OP_FIT, 32767, 32767, 32767, 32766, 0, 0),
                           0, cwlc_pkg::ST_JOINED, 0)};
    rows = {rows, make_row(make_point(OP_FIT, -32768, 0, 32767, 0, -32768, -32768),
                           0, cwlc_pkg::ST_JOINED, 0)};
    rows = {rows, make_row(make_point(OP_PREDICT, -1, -1, -1, -1, -1, -1),
                           0, cwlc_pkg::ST_JOINED, 0)};
    foreach (rows[r]) send_point(rows[r].pt, rows[r].typed, rows[r].want);

    // Each phase retunes the registers on an idle block, then runs random traffic.
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(cwlc_pkg::REG_WEIGHT, cwlc_pkg::THR_W'(weights[ph]));
      write_reg(cwlc_pkg::REG_THRESHOLD, cwlc_pkg::THR_W'(limits[ph]));
      gaps_on = (ph != 4);
      repeat (228) send_point(random_point(), 1'b0, none);
    end
    gaps_on = 1'b1;

    drain();
    repeat (2000) @(posedge clk);
    if (errors == 0) begin
      $display("PASS context_weighted_leader_clustering_unit");
    end else begin
      $display("FAIL context_weighted_leader_clustering_unit");
    end
    $finish;
  end

endmodule
